FILE: hdl/ctc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_pkg
// Types, constants and altitude-banded threshold tables shared by the
// collision threat classifier.
// ----------------------------------------------------------------------------
package ctc_pkg;

	localparam int DEFAULT_SLOTS = 16;

	// shared divider geometry
	localparam int NW         = 52;   // dividend magnitude bits
	localparam int DW         = 32;   // divisor magnitude bits
	localparam int QW         = 42;   // quotient bits
	localparam int QSAT_BITS  = 16;   // quotient bits of a saturating divide
	localparam int QFULL_BITS = 42;   // quotient bits of a full divide
	localparam int CNT_W      = 6;

	localparam logic [15:0] TAU_SAT = 16'hFFFF;

	localparam logic signed [17:0] CLAMP_LIMIT = 18'sd3500;
	localparam logic signed [17:0] GAUGE_MAX   = 18'sd4000;

	localparam logic CFG_PROX_RANGE = 1'b0;
	localparam logic CFG_PROX_ALT   = 1'b1;

	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_PROX = 2'd1,
		CLS_TA   = 2'd2,
		CLS_RA   = 2'd3
	} class_t;

	typedef enum logic [1:0] {
		SENSE_NONE = 2'd0,
		SENSE_UP   = 2'd1,
		SENSE_DOWN = 2'd2
	} sense_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_CHECK,
		DIV_RUN
	} div_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_VT_GO,
		ST_VT_WAIT,
		ST_TA_GO,
		ST_TA_WAIT,
		ST_RA_GO,
		ST_RA_WAIT,
		ST_CLASS,
		ST_CI_MUL,
		ST_CI_GO,
		ST_CI_WAIT,
		ST_CO_MUL,
		ST_CO_GO,
		ST_CO_WAIT,
		ST_V1,
		ST_V2,
		ST_V_GO,
		ST_V_WAIT,
		ST_DONE
	} state_t;

	function automatic logic [2:0] alt_band(input logic signed [16:0] alt);
		if (alt < 17'sd1000) return 3'd0;
		else if (alt < 17'sd2350) return 3'd1;
		else if (alt < 17'sd5000) return 3'd2;
		else if (alt < 17'sd10000) return 3'd3;
		else if (alt < 17'sd20000) return 3'd4;
		else return 3'd5;
	endfunction

	// squared distance modifiers, (1/1024 nmi)^2
	function automatic logic [20:0] ta_dmod_sq(input logic [2:0] b);
		case (b)
			3'd0: return 21'd94249;
			3'd1: return 21'd114244;
			3'd2: return 21'd242064;
			3'd3: return 21'd589824;
			3'd4: return 21'd1048576;
			default: return 21'd1771561;
		endcase
	endfunction

	function automatic logic [20:0] ra_dmod_sq(input logic [2:0] b);
		case (b)
			3'd0: return 21'd0;
			3'd1: return 21'd42025;
			3'd2: return 21'd128164;
			3'd3: return 21'd316969;
			3'd4: return 21'd670761;
			default: return 21'd1267876;
		endcase
	endfunction

	// tau thresholds in 1/16 s
	function automatic logic [9:0] ta_th(input logic [2:0] b);
		case (b)
			3'd0: return 10'd320;
			3'd1: return 10'd400;
			3'd2: return 10'd480;
			3'd3: return 10'd640;
			3'd4: return 10'd720;
			default: return 10'd768;
		endcase
	endfunction

	function automatic logic [9:0] ra_th(input logic [2:0] b);
		case (b)
			3'd0: return 10'd0;
			3'd1: return 10'd240;
			3'd2: return 10'd320;
			3'd3: return 10'd400;
			3'd4: return 10'd480;
			default: return 10'd560;
		endcase
	endfunction

	function automatic logic [17:0] ra_zthr(input logic signed [16:0] alt);
		if (alt < 17'sd5000) return 18'd300;
		else if (alt < 17'sd10000) return 18'd350;
		else if (alt < 17'sd20000) return 18'd400;
		else if (alt < 17'sd42000) return 18'd600;
		else return 18'd700;
	endfunction

	function automatic logic signed [10:0] alim_ft(input logic signed [16:0] alt);
		if (alt < 17'sd1000) return -11'sd1;
		else if (alt < 17'sd20000) return 11'sd600;
		else if (alt < 17'sd42000) return 11'sd700;
		else return 11'sd800;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/ctc_class_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_class_mem
// Per-slot threat class store: synchronous RAM with registered read and a
// valid bit per slot so that unwritten slots read as non-threat.
// ----------------------------------------------------------------------------
module ctc_class_mem import ctc_pkg::*; #(
	parameter int SLOTS = DEFAULT_SLOTS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 rd_en,
	input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
	output logic      [1:0]                           rd_data,
	input  wire logic                                 wr_en,
	input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr,
	input  wire logic [1:0]                           wr_data
);
	logic [1:0]       mem [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic [1:0]       rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			if (rd_en) rvld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rvld_q ? rdata_q : 2'd0;

endmodule
`default_nettype wire

FILE: hdl/ctc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_divider
// Unsigned shift-subtract divider, one quotient bit per cycle. In saturating
// mode the quotient is capped at 65535 and only 16 bits are worked out.
// ----------------------------------------------------------------------------
module ctc_divider import ctc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic          sat_mode,
	output logic               done,
	output logic      [QW-1:0] quot
);
	div_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [NW-1:0]     n_q;
	logic [DW-1:0]     d_q;
	logic [DW-1:0]     p_q;
	logic [QW-1:0]     q_q;
	logic              sat_q;
	logic              over;
	logic [DW:0]       trial;
	logic              ge;

	assign over  = n_q >= NW'({d_q, QSAT_BITS'(0)});
	assign trial = {p_q, n_q[NW-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE:  if (start) state_d = DIV_CHECK;
			DIV_CHECK: state_d = (sat_q && over) ? DIV_IDLE : DIV_RUN;
			DIV_RUN:   if (cnt_q == CNT_W'(1)) state_d = DIV_IDLE;
			default:   state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DIV_CHECK && sat_q && over) ||
			           (state_q == DIV_RUN && cnt_q == CNT_W'(1));
			if (state_q == DIV_CHECK)
				cnt_q <= sat_q ? CNT_W'(QSAT_BITS) : CNT_W'(QFULL_BITS);
			else if (state_q == DIV_RUN)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					n_q   <= num;
					d_q   <= den;
					sat_q <= sat_mode;
				end
			end
			DIV_CHECK: begin
				if (sat_q && over) begin
					q_q <= QW'(TAU_SAT);
				end else begin
					// top bits go straight to the partial remainder, the rest shift in
					p_q <= sat_q ? DW'(n_q >> QSAT_BITS) : DW'(n_q >> QFULL_BITS);
					n_q <= sat_q ? (n_q << (NW - QSAT_BITS)) : (n_q << (NW - QFULL_BITS));
					q_q <= '0;
				end
			end
			DIV_RUN: begin
				p_q <= ge ? DW'(trial - {1'b0, d_q}) : DW'(trial);
				n_q <= n_q << 1;
				q_q <= {q_q[QW-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign quot = q_q;

endmodule
`default_nettype wire

FILE: hdl/collision_threat_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// collision_threat_classifier
// Tau-based threat classification of one intruder update per word, with
// per-slot class hysteresis, sense selection and vertical-speed bands.
// ----------------------------------------------------------------------------
// One update is worked on at a time. The time from acceptance to result is
// longest when a resolution advisory carries bands, and is set by the single
// shared shift-subtract divider (one quotient bit per cycle: 16 bits for the
// vertical tau, each range tau and the band speed, 42 bits for each projected
// climb, plus a start, a check and a hand-off per divide). A divide that
// saturates ends right after its check cycle. The next word is accepted as
// soon as the result sits in the output register. The class store needs no
// clearing pass: slots read as non-threat until written.
module collision_threat_classifier import ctc_pkg::*; #(
	parameter int INTRUDER_SLOTS = DEFAULT_SLOTS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// intruder_slot, slant_range, closing_speed, own_altitude, own_altitude_old,
	// intruder_altitude, intruder_altitude_old, own_elapsed, intruder_elapsed,
	// peer_sense
	input  wire logic [135:0] s_tdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// threat_class, chosen_sense, send_sense, bands_valid, recommended_min,
	// recommended_max, danger_min, danger_max
	output logic      [63:0]  m_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [15:0]  cfg_data
);
	localparam int SW = INTRUDER_SLOTS > 1 ? $clog2(INTRUDER_SLOTS) : 1;

	state_t state_q, state_d;

	logic [15:0] prox_range_q;
	logic [13:0] prox_alt_q;

	logic [SW-1:0] slot_map [16];
	for (genvar g = 0; g < 16; g++) begin : g_slot
		assign slot_map[g] = SW'(g % INTRUDER_SLOTS);
	end

	// captured update
	logic [SW-1:0]      slot_q;
	logic [15:0]        r_q;
	logic signed [12:0] c_q;
	logic signed [16:0] own_q, own_old_q, intr_q, intr_old_q;
	logic [15:0]        own_el_q, intr_el_q;
	logic [1:0]         peer_q;

	// working registers
	logic [31:0]        rr_q;
	logic signed [29:0] rc_q;
	logic [33:0]        vn_q;
	logic [17:0]        vsep_q;
	logic signed [18:0] conv_q;
	logic [2:0]         band_q;
	logic [15:0]        vtau_q;
	logic signed [16:0] ta_tau_q, ra_tau_q;
	logic               neg_q;
	logic signed [34:0] cm_q;
	logic signed [41:0] ci_q, co_q;
	logic signed [42:0] pi_q, po_q;
	logic signed [44:0] a_q;
	class_t             cls_q;
	sense_t             sense_q;
	logic               send_q, bval_q;
	logic [12:0]        rmin_q, rmax_q, dmin_q, dmax_q;

	// output register
	logic        out_full_q;
	class_t      out_cls_q;
	sense_t      out_sense_q;
	logic        out_send_q, out_bval_q;
	logic [12:0] out_rmin_q, out_rmax_q, out_dmin_q, out_dmax_q;

	logic accept, load;
	logic div_start, div_sat, div_done;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	logic [QW-1:0] div_q;
	logic mem_we;
	logic [1:0] mem_rd;
	class_t prev_cls, cls;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign load      = (state_q == ST_DONE) && (!out_full_q || m_tready);

	ctc_class_mem #(.SLOTS(INTRUDER_SLOTS)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (slot_map[s_tdata[3:0]]),
		.rd_data (mem_rd),
		.wr_en   (mem_we),
		.wr_addr (slot_q),
		.wr_data (cls)
	);
	assign prev_cls = class_t'(mem_rd);

	ctc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.den      (div_den),
		.sat_mode (div_sat),
		.done     (div_done),
		.quot     (div_q)
	);

	// ---- first stage: separations and products
	logic signed [17:0] diff_now, diff_old;
	logic [17:0]        vsep_now, sep_old;
	logic signed [18:0] conv_d;
	logic [31:0]        rr;
	logic signed [29:0] rc;
	logic [33:0]        vn;

	assign diff_now = $signed({intr_q[16], intr_q}) - $signed({own_q[16], own_q});
	assign diff_old = $signed({intr_old_q[16], intr_old_q}) - $signed({own_old_q[16], own_old_q});
	assign vsep_now = diff_now[17] ? 18'(-diff_now) : 18'(diff_now);
	assign sep_old  = diff_old[17] ? 18'(-diff_old) : 18'(diff_old);
	assign conv_d   = $signed({1'b0, sep_old}) - $signed({1'b0, vsep_now});
	assign rr       = r_q * r_q;
	assign rc       = $signed({1'b0, r_q}) * c_q;
	assign vn       = vsep_now * intr_el_q;

	// ---- divider operands
	logic               conv_pos;
	logic [34:0]        vt_num;
	logic [24:0]        vt_den;
	logic [20:0]        dd;
	logic signed [33:0] mt_diff;
	logic signed [41:0] mt_num;
	logic [41:0]        mt_mag;
	logic signed [31:0] mt_den;
	logic [31:0]        mt_den_mag;
	logic signed [17:0] dalt;
	logic signed [34:0] cm;
	logic signed [41:0] cl_num;
	logic [41:0]        cl_mag;
	logic [15:0]        el;
	logic [16:0]        cl_den;
	logic signed [43:0] sep_d;
	logic [43:0]        sep;
	logic [44:0]        a_mag;
	logic [51:0]        v_num;

	assign conv_pos   = !conv_q[18] && (conv_q != 19'sd0);
	assign vt_num     = {vn_q, 1'b0};
	assign vt_den     = conv_q[17:0] * 25'd125;
	assign dd         = (state_q == ST_TA_GO) ? ta_dmod_sq(band_q) : ra_dmod_sq(band_q);
	assign mt_diff    = $signed({2'b00, rr_q}) - $signed({13'd0, dd});
	assign mt_num     = 42'(mt_diff) * 42'sd225;
	assign mt_mag     = mt_num[41] ? 42'(-mt_num) : 42'(mt_num);
	assign mt_den     = $signed({rc_q, 2'b00});
	assign mt_den_mag = mt_den[31] ? 32'(-mt_den) : 32'(mt_den);

	assign dalt   = (state_q == ST_CO_MUL)
		? $signed({own_q[16], own_q}) - $signed({own_old_q[16], own_old_q})
		: $signed({intr_q[16], intr_q}) - $signed({intr_old_q[16], intr_old_q});
	assign cm     = 35'(dalt) * $signed({19'd0, ra_tau_q[15:0]});
	assign cl_num = 42'(cm_q) * 42'sd125;
	assign cl_mag = cl_num[41] ? 42'(-cl_num) : 42'(cl_num);
	assign el     = (state_q == ST_CO_GO) ? own_el_q : intr_el_q;
	assign cl_den = {el, 1'b0};

	assign sep_d = 44'(pi_q) - 44'(po_q);
	assign sep   = sep_d[43] ? 44'(-sep_d) : 44'(sep_d);
	assign a_mag = a_q[44] ? 45'(-a_q) : 45'(a_q);
	assign v_num = 52'(a_mag) * 52'd960;

	// ---- divider results
	logic signed [16:0] q_s17;
	logic signed [41:0] q_s42;
	logic signed [17:0] v, v_upc, v_up, w, w_c, v_dn;

	assign q_s17 = neg_q ? -$signed({1'b0, div_q[15:0]}) : $signed({1'b0, div_q[15:0]});
	assign q_s42 = neg_q ? -$signed(div_q) : $signed(div_q);
	assign v     = neg_q ? -$signed({2'b00, div_q[15:0]}) : $signed({2'b00, div_q[15:0]});
	assign v_upc = (v > CLAMP_LIMIT) ? CLAMP_LIMIT : v;
	assign v_up  = (v_upc < -GAUGE_MAX) ? -GAUGE_MAX : v_upc;
	assign w     = -v;
	assign w_c   = (w < -CLAMP_LIMIT) ? -CLAMP_LIMIT : w;
	assign v_dn  = (w_c > GAUGE_MAX) ? GAUGE_MAX : w_c;

	// ---- classification
	logic ta_ok, ra_ok, ra_pos;
	logic signed [16:0] ta_thr, ra_thr;

	assign ta_thr = $signed({7'd0, ta_th(band_q)});
	assign ra_thr = $signed({7'd0, ra_th(band_q)});
	assign ra_pos = !ra_tau_q[16] && (ra_tau_q != 17'sd0);

	always_comb begin
		if (vsep_q > ((own_q < 17'sd42000) ? 18'd850 : 18'd1200))
			ta_ok = (ta_tau_q < ta_thr) && ({1'b0, vtau_q} < 17'(ta_th(band_q)));
		else
			ta_ok = ta_tau_q < ta_thr;

		if (band_q == 3'd0)
			ra_ok = 1'b0;
		else if (vsep_q > ra_zthr(own_q))
			ra_ok = (ra_tau_q < ra_thr) && ({1'b0, vtau_q} < 17'(ra_th(band_q)));
		else
			ra_ok = ra_tau_q < ra_thr;

		cls = CLS_NONE;
		if (r_q < prox_range_q && vsep_q < 18'(prox_alt_q)) begin
			if (c_q > 13'sd0 && ((prev_cls inside {CLS_TA, CLS_RA}) || ta_ok))
				cls = (prev_cls == CLS_RA || ra_ok) ? CLS_RA : CLS_TA;
			else
				cls = CLS_PROX;
		end
	end

	// ---- sequencer
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_sat   = 1'b1;
		div_num   = '0;
		div_den   = '0;
		mem_we    = 1'b0;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_PREP;
			ST_PREP:  state_d = ST_VT_GO;
			ST_VT_GO: begin
				div_num   = NW'(vt_num);
				div_den   = DW'(vt_den);
				div_start = conv_pos;
				state_d   = conv_pos ? ST_VT_WAIT : ST_TA_GO;
			end
			ST_VT_WAIT: if (div_done) state_d = ST_TA_GO;
			ST_TA_GO, ST_RA_GO: begin
				div_num   = NW'(mt_mag);
				div_den   = mt_den_mag;
				div_start = (rc_q != 30'sd0);
				if (state_q == ST_TA_GO)
					state_d = div_start ? ST_TA_WAIT : ST_RA_GO;
				else
					state_d = div_start ? ST_RA_WAIT : ST_CLASS;
			end
			ST_TA_WAIT: if (div_done) state_d = ST_RA_GO;
			ST_RA_WAIT: if (div_done) state_d = ST_CLASS;
			ST_CLASS: begin
				mem_we  = 1'b1;
				state_d = (cls == CLS_RA && ra_pos) ? ST_CI_MUL : ST_DONE;
			end
			ST_CI_MUL: state_d = ST_CI_GO;
			ST_CO_MUL: state_d = ST_CO_GO;
			ST_CI_GO, ST_CO_GO: begin
				div_num   = NW'(cl_mag);
				div_den   = DW'(cl_den);
				div_sat   = 1'b0;
				div_start = (el != 16'd0);
				if (state_q == ST_CI_GO)
					state_d = div_start ? ST_CI_WAIT : ST_CO_MUL;
				else
					state_d = div_start ? ST_CO_WAIT : ST_V1;
			end
			ST_CI_WAIT: if (div_done) state_d = ST_CO_MUL;
			ST_CO_WAIT: if (div_done) state_d = ST_V1;
			ST_V1:      state_d = ST_V2;
			ST_V2:      state_d = ST_V_GO;
			ST_V_GO: begin
				div_num   = v_num;
				div_den   = DW'(ra_tau_q[15:0]);
				div_start = 1'b1;
				state_d   = ST_V_WAIT;
			end
			ST_V_WAIT: if (div_done) state_d = ST_DONE;
			ST_DONE:   if (load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_full_q   <= 1'b0;
			prox_range_q <= 16'd6144;
			prox_alt_q   <= 14'd1200;
		end else begin
			state_q <= state_d;
			if (load) out_full_q <= 1'b1;
			else if (m_tready) out_full_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PROX_RANGE: prox_range_q <= cfg_data;
					CFG_PROX_ALT:   prox_alt_q   <= cfg_data[13:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					slot_q     <= slot_map[s_tdata[3:0]];
					r_q        <= s_tdata[19:4];
					c_q        <= s_tdata[32:20];
					own_q      <= s_tdata[49:33];
					own_old_q  <= s_tdata[66:50];
					intr_q     <= s_tdata[83:67];
					intr_old_q <= s_tdata[100:84];
					own_el_q   <= s_tdata[116:101];
					intr_el_q  <= s_tdata[132:117];
					peer_q     <= s_tdata[134:133];
				end
			end
			ST_PREP: begin
				rr_q    <= rr;
				rc_q    <= rc;
				vn_q    <= vn;
				vsep_q  <= vsep_now;
				conv_q  <= conv_d;
				band_q  <= alt_band(own_q);
				sense_q <= SENSE_NONE;
				send_q  <= 1'b0;
				bval_q  <= 1'b0;
				rmin_q  <= '0;
				rmax_q  <= '0;
				dmin_q  <= '0;
				dmax_q  <= '0;
			end
			ST_VT_GO:   if (!conv_pos) vtau_q <= TAU_SAT;
			ST_VT_WAIT: if (div_done) vtau_q <= div_q[15:0];
			ST_TA_GO: begin
				neg_q <= mt_num[41] ^ rc_q[29];
				if (rc_q == 30'sd0) ta_tau_q <= $signed({1'b0, TAU_SAT});
			end
			ST_TA_WAIT: if (div_done) ta_tau_q <= q_s17;
			ST_RA_GO: begin
				neg_q <= mt_num[41] ^ rc_q[29];
				if (rc_q == 30'sd0) ra_tau_q <= $signed({1'b0, TAU_SAT});
			end
			ST_RA_WAIT: if (div_done) ra_tau_q <= q_s17;
			ST_CLASS: begin
				cls_q <= cls;
				if (cls == CLS_RA) begin
					if (peer_q == SENSE_UP || peer_q == SENSE_DOWN) begin
						sense_q <= sense_t'(peer_q);
					end else begin
						sense_q <= (own_q > intr_q) ? SENSE_UP : SENSE_DOWN;
						send_q  <= 1'b1;
					end
				end
			end
			ST_CI_MUL, ST_CO_MUL: cm_q <= cm;
			ST_CI_GO: begin
				neg_q <= cl_num[41];
				if (el == 16'd0) ci_q <= '0;
			end
			ST_CI_WAIT: if (div_done) ci_q <= q_s42;
			ST_CO_GO: begin
				neg_q <= cl_num[41];
				if (el == 16'd0) co_q <= '0;
			end
			ST_CO_WAIT: if (div_done) co_q <= q_s42;
			ST_V1: begin
				pi_q <= 43'(intr_q) + 43'(ci_q);
				po_q <= 43'(own_q) + 43'(co_q);
			end
			ST_V2:   a_q <= 45'(alim_ft(own_q)) - $signed({1'b0, sep});
			ST_V_GO: neg_q <= a_q[44];
			ST_V_WAIT: begin
				if (div_done) begin
					bval_q <= 1'b1;
					if (sense_q == SENSE_UP) begin
						rmin_q <= 13'(v_up);
						rmax_q <= 13'(GAUGE_MAX);
						dmin_q <= 13'(-GAUGE_MAX);
						dmax_q <= 13'(v_up);
					end else begin
						rmin_q <= 13'(-GAUGE_MAX);
						rmax_q <= 13'(v_dn);
						dmin_q <= 13'(v_dn);
						dmax_q <= 13'(GAUGE_MAX);
					end
				end
			end
			ST_DONE: begin
				if (load) begin
					out_cls_q   <= cls_q;
					out_sense_q <= sense_q;
					out_send_q  <= send_q;
					out_bval_q  <= bval_q;
					out_rmin_q  <= rmin_q;
					out_rmax_q  <= rmax_q;
					out_dmin_q  <= dmin_q;
					out_dmax_q  <= dmax_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_full_q;
	assign m_tdata  = {6'd0, out_dmax_q, out_dmin_q, out_rmax_q, out_rmin_q,
	                   out_bval_q, out_send_q, out_sense_q, out_cls_q};

endmodule
`default_nettype wire
